// ----- hw/rtl/b64enc_pkg.sv -----
// shared types, constants and alphabet lookup for the base64 stream encoder
`default_nettype none

package b64enc_pkg;

	localparam int B64_QUEUE_DEPTH = 2;

	localparam logic [7:0] B64_PAD_CHAR = 8'h3D;

	// one byte group waiting for character output
	typedef struct packed {
		logic [23:0] bits;  // three bytes, zero filled
		logic [1:0]  pad;   // number of trailing '=' characters
	} b64_group_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic avail;
	} b64_qstat_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [7:0] b64_char(input logic [5:0] sextet);
		logic [7:0] s;
		logic [7:0] c;
		begin
			s = {2'b00, sextet};
			if (sextet < 6'd26) begin
				c = 8'd65 + s;
			end else if (sextet < 6'd52) begin
				c = 8'd71 + s;
			end else if (sextet < 6'd62) begin
				c = s - 8'd4;
			end else if (sextet == 6'd62) begin
				c = 8'h2B;
			end else begin
				c = 8'h2F;
			end
			return c;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/base64_stream_encoder_top.sv -----
// top level of the base64 stream encoder
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | into      | in_valid / in_ready  | data_byte, final_byte
//  out     | out of    | out_valid / out_ready| out_char, end_of_run
//
// every third byte, or a final byte, turns into one queued group. the back end
// sends four characters per group at one per cycle while a group is queued and
// the output is not stalled, so the output port sets the sustained rate.
// the front keeps taking bytes while the group queue has room, so the output
// may stall without stopping input until the queue fills.
// arst_n clears pending bytes, queue pointers and the output valid flag.
`default_nettype none

module base64_stream_encoder_top
	import b64enc_pkg::*;
#(
	parameter int QueueDepth = B64_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            end_of_run
);

	// groups move from front to back through the queue
	b64_qstat_t qstat;
	b64_group_t push_group;
	b64_group_t head;
	logic       push;
	logic       pop;

	// front: byte transfer, grouping, zero fill and pad count
	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.qstat      (qstat),
		.push       (push),
		.push_group (push_group)
	);

	// short queue decoupling the byte side from the character side
	b64enc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back: sextet selection, alphabet lookup and output register
	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/b64enc_front.sv -----
// front end: accepts bytes, gathers groups of three and queues finished groups
`default_nettype none

module b64enc_front
	import b64enc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire b64_qstat_t qstat,
	output logic            push,
	output b64_group_t      push_group
);

	logic [1:0]  cnt_q;
	logic [15:0] pend_q;
	logic        accept;
	logic        full_grp;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	// a count of three would act as two
	assign full_grp = cnt_q[1];

	always_comb begin
		b0 = (cnt_q == 2'd0) ? data_byte : pend_q[15:8];
		if (full_grp) begin
			b1 = pend_q[7:0];
		end else if (cnt_q == 2'd1) begin
			b1 = data_byte;
		end else begin
			b1 = 8'h00;
		end
		b2 = full_grp ? data_byte : 8'h00;
	end

	assign push            = accept && (full_grp || final_byte);
	assign push_group.bits = {b0, b1, b2};
	assign push_group.pad  = full_grp ? 2'd0 : ((cnt_q == 2'd1) ? 2'd1 : 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pend_q <= 16'h0000;
		end else if (accept) begin
			if (full_grp || final_byte) begin
				cnt_q  <= 2'd0;
				pend_q <= 16'h0000;
			end else begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd0) begin
					pend_q <= {data_byte, 8'h00};
				end else begin
					pend_q <= {pend_q[15:8], data_byte};
				end
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("pending count reached three");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/b64enc_queue.sv -----
// short group queue between front and back
`default_nettype none

module b64enc_queue
	import b64enc_pkg::*;
#(
	parameter int Depth = B64_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire b64_group_t push_group,
	input  wire logic       pop,
	output b64_group_t      head,
	output b64_qstat_t      qstat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	b64_group_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign qstat.full  = (count_q == CntW'(Depth));
	assign qstat.avail = (count_q != '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.avail)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/b64enc_back.sv -----
// back end: each queued group becomes four characters, one per unstalled cycle
`default_nettype none

module b64enc_back
	import b64enc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire b64_group_t head,
	input  wire b64_qstat_t qstat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            end_of_run
);

	logic [1:0] k_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       end_q;
	logic       load;
	logic [5:0] sextet;
	logic [2:0] pos_sum;

	assign load = qstat.avail && (!out_valid_q || out_ready);
	assign pop  = load && (k_q == 2'd3);

	always_comb begin
		case (k_q)
			2'd0:    sextet = head.bits[23:18];
			2'd1:    sextet = head.bits[17:12];
			2'd2:    sextet = head.bits[11:6];
			default: sextet = head.bits[5:0];
		endcase
	end

	// padding covers the last pad positions
	assign pos_sum = {1'b0, k_q} + {1'b0, head.pad};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= k_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= pos_sum[2] ? B64_PAD_CHAR : b64_char(sextet);
			end_q  <= (k_q == 2'd3);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = char_q;
	assign end_of_run = end_q;

`ifndef SYNTH
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 2'd0 |-> qstat.avail)
		else $error("group left the queue before all characters were sent");
`endif

endmodule

`default_nettype wire

// ----- sim/b64enc_checker.sv -----
// checker for the base64 stream encoder: predicts characters from input transfers and compares
module b64enc_checker
	import b64enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic       end_of_run,
	output int         chars_due,
	output int         chars_seen,
	output int         mismatches
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	enc_char_t   chars_due_q[$];
	int          mismatch_total;
	int          seen_total;

	function automatic logic [7:0] sextet_char(input logic [5:0] sx);
		return ALPHABET[8*(63 - sx) +: 8];
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_total++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// appends the characters that one byte causes, if any
	function automatic void encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [5:0] sx[4];
		int         have;
		int         nchars;
		enc_char_t  c;
		if (held_count < 2'd2) begin
			if (held_count == 2'd0) begin
				held_bytes = {b, 8'h00};
			end else begin
				held_bytes[7:0] = b;
			end
			held_count++;
			if (!fin) begin
				return;
			end
			// partial group, zero filled
			have = int'(held_count);
			b0   = held_bytes[15:8];
			b1   = (held_count == 2'd2) ? held_bytes[7:0] : 8'h00;
			b2   = 8'h00;
		end else begin
			have = 3;
			b0   = held_bytes[15:8];
			b1   = held_bytes[7:0];
			b2   = b;
		end
		sx[0]  = b0[7:2];
		sx[1]  = {b0[1:0], b1[7:4]};
		sx[2]  = {b1[3:0], b2[7:6]};
		sx[3]  = b2[5:0];
		nchars = (have == 3) ? 4 : have + 1;
		for (int k = 0; k < 4; k++) begin
			c.ch   = (k < nchars) ? sextet_char(sx[k]) : B64_PAD_CHAR;
			c.last = (k == 3);
			chars_due_q.insert(chars_due_q.size(), c);
		end
		held_bytes = 16'h0000;
		held_count = 2'd0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		enc_char_t want;
		if (!arst_n) begin
			held_bytes     = 16'h0000;
			held_count     = 2'd0;
			mismatch_total = 0;
			seen_total     = 0;
			chars_due_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				encode_byte(data_byte, final_byte);
			end
			if (out_valid && out_ready) begin
				seen_total++;
				if (chars_due_q.size() == 0) begin
					report_mismatch($sformatf("unexpected character 8'h%02h", out_char));
				end else begin
					want = chars_due_q.pop_front();
					if (out_char !== want.ch) begin
						report_mismatch($sformatf("out_char 8'h%02h, want 8'h%02h",
							out_char, want.ch));
					end
					if (end_of_run !== want.last) begin
						report_mismatch($sformatf("end_of_run %b, want %b",
							end_of_run, want.last));
					end
				end
			end
		end
		chars_due  <= chars_due_q.size();
		chars_seen <= seen_total;
		mismatches <= mismatch_total;
	end

endmodule

// ----- sim/tb_base64_stream_encoder_top.sv -----
// testbench top for the base64 stream encoder: stimulus, flow control and verdict
module tb_base64_stream_encoder_top;

	// run shape
	localparam int TOTAL_ITEMS      = 230;
	localparam int CALM_FROM        = 195;   // no idling on either side from here on
	localparam int LONG_HOLD_AT     = 70;    // receiver holds off once this many bytes are in
	localparam int LONG_HOLD_CYCLES = 40;
	localparam int PAUSE_AT         = 130;   // sender drains the block once past this point
	localparam int DRAIN_LIMIT      = 2000;
	localparam int TAIL_CYCLES      = 20;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte  = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] out_char;
	logic       end_of_run;

	int chars_due;
	int chars_seen;
	int mismatches;

	int bytes_sent   = 0;
	int streams_sent = 0;
	bit calm         = 1'b0;

	always #4 clk = ~clk;

	base64_stream_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.end_of_run (end_of_run)
	);

	b64enc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.end_of_run (end_of_run),
		.chars_due  (chars_due),
		.chars_seen (chars_seen),
		.mismatches (mismatches)
	);

	// offers one byte and holds it until the transfer, then maybe idles a short burst
	task automatic put_byte(input logic [7:0] b, input logic fin);
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (fin) begin
			streams_sent++;
		end
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// sender goes quiet until every predicted character has come out
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (chars_due != 0);
	endtask

	// random stream of len bytes, flagged final on the last one
	task automatic put_stream(input int len);
		for (int i = 0; i < len; i++) begin
			put_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	// sender side: reset, directed streams, then random traffic
	initial begin : feed_side
		int  kind;
		int  waited;
		bit  paused;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone final byte at both extremes: two characters and double padding
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b1);
		// two byte streams: three characters and single padding
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b1);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		// final byte closing a full group, so no padding
		put_byte(8'h4D, 1'b0);
		put_byte(8'h61, 1'b0);
		put_byte(8'h6E, 1'b1);
		// full group mid-stream, then a one byte tail
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hA5, 1'b1);
		// full group mid-stream, then a two byte tail
		put_byte(8'h01, 1'b0);
		put_byte(8'h02, 1'b0);
		put_byte(8'h03, 1'b0);
		put_byte(8'h04, 1'b0);
		put_byte(8'h05, 1'b1);
		drain_block();

		while (bytes_sent < TOTAL_ITEMS) begin
			if (bytes_sent >= CALM_FROM) begin
				calm <= 1'b1;
			end
			if (!paused && bytes_sent >= PAUSE_AT) begin
				paused = 1'b1;
				drain_block();
			end
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				put_stream($urandom_range(1, 7));
			end else if (kind < 8) begin
				put_stream($urandom_range(8, 20));
			end else begin
				// loose bytes with a random end flag, streams cut at odd places
				repeat ($urandom_range(1, 4)) begin
					put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
			end
		end
		in_valid <= 1'b0;

		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (chars_due != 0 && waited < DRAIN_LIMIT);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d bytes in %0d streams, %0d characters compared",
			bytes_sent, streams_sent, chars_seen);
		$display("directed padding cases plus random streams, long output hold and full drain");
		if (mismatches == 0 && chars_due == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// receiver side: short random stalls, one long hold-off to fill the group queue
	initial begin : drain_side
		int stall_left;
		bit long_done;
		stall_left = 0;
		long_done  = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!long_done && bytes_sent >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				// start a stall burst; stall_left counts the stalled cycles still to come
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#1600000;
		$display("timeout waiting for the encoder");
		$display("Some tests failed");
		$finish;
	end

endmodule
